/* hw/rtl/pfla_pkg.sv */
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared constants, codes and types of the page free list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

    localparam int NUM_PAGES  = 1024;
    localparam int NUM_CHUNKS = 4 * NUM_PAGES;
    localparam int PIDX_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CIDX_W     = PIDX_W + 2;
    localparam int PHEAD_W    = $clog2(NUM_PAGES + 1);
    localparam int CHEAD_W    = $clog2(NUM_CHUNKS + 1);
    localparam int FBS_W      = ((CHEAD_W + 10 > PHEAD_W + 12) ? CHEAD_W + 10 : PHEAD_W + 12) + 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [PHEAD_W-1:0] PAGE_EMPTY  = PHEAD_W'(NUM_PAGES);
    localparam logic [CHEAD_W-1:0] CHUNK_EMPTY = CHEAD_W'(NUM_CHUNKS);
    localparam logic [22:0]        FB_MAX      = 23'h7FFFFF;

    localparam logic [2:0] FN_INIT    = 3'd0;
    localparam logic [2:0] FN_ALLOC4K = 3'd1;
    localparam logic [2:0] FN_FREE4K  = 3'd2;
    localparam logic [2:0] FN_ALLOC1K = 3'd3;
    localparam logic [2:0] FN_FREE1K  = 3'd4;
    localparam logic [2:0] FN_QUERY   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic [2:0] REG_REGION_START = 3'd0;
    localparam logic [2:0] REG_REGION_END   = 3'd1;
    localparam logic [2:0] REG_SKIP_HOLES   = 3'd2;
    localparam logic [2:0] REG_HOLE0_BASE   = 3'd3;
    localparam logic [2:0] REG_HOLE0_END    = 3'd4;
    localparam logic [2:0] REG_HOLE1_BASE   = 3'd5;
    localparam logic [2:0] REG_HOLE1_END    = 3'd6;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] addr;
    } req_t;

    typedef struct packed {
        logic [31:0] alloc_addr;
        logic [1:0]  status;
        logic [22:0] free_bytes;
    } rsp_t;

    typedef struct packed {
        logic [31:0] region_start;
        logic [31:0] region_end;
        logic        skip_holes;
        logic [31:0] hole0_base;
        logic [31:0] hole0_end;
        logic [31:0] hole1_base;
        logic [31:0] hole1_end;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_INIT,
        OP_ALLOC4K,
        OP_FREE4K,
        OP_ALLOC1K,
        OP_FREE1K,
        OP_QUERY,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CIDX_W-1:0]  idx;
        logic [32:0]        base;
        logic [PHEAD_W-1:0] npages;
    } qent_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_INIT,
        BK_PG_WAIT,
        BK_CK_WAIT,
        BK_SPLIT_WAIT,
        BK_SPLIT
    } bk_state_t;

endpackage

/* hw/rtl/page_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// page_free_list_allocator
// LIFO free lists of 4 KB pages and 1 KB chunks over a configured region.
//
//   channel    signals                          direction  transfer
//   request    start, busy, req                 in         start && !busy
//   result     done, rsp                        out        done, one cycle
//   config     cfg_we, cfg_index, cfg_data      in         cfg_we
//
// A taken request passes the front stage register and the queue before it
// reaches the back; the result is registered in the cycle after the back
// finishes. A free, a query or an empty allocation ends in idle; an
// allocation waits for the registered read of a link memory's single read
// port; a page split writes its four chunks; an init visits every region page.
// Reset empties both lists at once; the link memories are not cleared.
// Results cannot be held off; busy rises only when the queue and the front
// stage are both full.
// ----------------------------------------------------------------------------
module page_free_list_allocator
    import pfla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    logic  q_push;
    qent_t q_push_ent;
    logic  q_pop;
    qent_t q_head_ent;
    logic  q_empty;
    logic  q_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_REGION_START: cfg_next.region_start = cfg_data;
                REG_REGION_END:   cfg_next.region_end   = cfg_data;
                REG_SKIP_HOLES:   cfg_next.skip_holes   = cfg_data[0];
                REG_HOLE0_BASE:   cfg_next.hole0_base   = cfg_data;
                REG_HOLE0_END:    cfg_next.hole0_end    = cfg_data;
                REG_HOLE1_BASE:   cfg_next.hole1_base   = cfg_data;
                REG_HOLE1_END:    cfg_next.hole1_end    = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pfla_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .busy     (busy),
        .push     (q_push),
        .push_ent (q_push_ent)
    );

    pfla_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_ent (q_push_ent),
        .pop      (q_pop),
        .head_ent (q_head_ent),
        .empty    (q_empty),
        .full     (q_full)
    );

    pfla_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_ent   (q_head_ent),
        .q_pop   (q_pop),
        .done    (done),
        .rsp     (rsp)
    );

endmodule

/* hw/rtl/pfla_front.sv */
// ----------------------------------------------------------------------------
// pfla_front
// Takes requests, checks free addresses against the latched region and
// works out the region at init, then hands a classified entry to the queue.
// ----------------------------------------------------------------------------
module pfla_front
    import pfla_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  req_t  req,
    input  cfg_t  cfg,
    input  logic  q_full,
    output logic  busy,
    output logic  push,
    output qent_t push_ent
);

    logic               valid_reg, valid_next;
    req_t               req_reg;
    logic [31:0]        base_reg, base_next;
    logic [PHEAD_W-1:0] pages_reg, pages_next;

    logic               accept;
    logic [32:0]        init_s;
    logic [32:0]        init_e;
    logic [32:0]        init_span;
    logic [20:0]        init_n_raw;
    logic [PHEAD_W-1:0] init_n;
    logic [31:0]        off;
    logic               addr_ge;
    logic               pg_ok;
    logic               ck_ok;

    assign accept = start && !busy;
    assign busy   = valid_reg && q_full;
    assign push   = valid_reg && !q_full;

    assign init_s     = ({1'b0, cfg.region_start} + 33'h0_0000_0FFF) & ~33'h0_0000_0FFF;
    assign init_e     = {1'b0, cfg.region_end[31:12], 12'h000};
    assign init_span  = (init_e > init_s) ? (init_e - init_s) : 33'd0;
    assign init_n_raw = init_span[32:12];
    assign init_n     = (init_n_raw > 21'(NUM_PAGES)) ? PAGE_EMPTY : PHEAD_W'(init_n_raw);

    assign addr_ge = req_reg.addr >= base_reg;
    assign off     = req_reg.addr - base_reg;
    assign pg_ok   = addr_ge && (off[11:0] == 12'h000)
                     && ({12'h000, off[31:12]} < 32'(pages_reg));
    assign ck_ok   = addr_ge && (off[9:0] == 10'h000)
                     && ({10'h000, off[31:10]} < (32'(pages_reg) << 2));

    always_comb
    begin
        push_ent.idx    = '0;
        push_ent.base   = init_s;
        push_ent.npages = init_n;
        case (req_reg.func)
            FN_INIT:    push_ent.op = OP_INIT;
            FN_ALLOC4K: push_ent.op = OP_ALLOC4K;
            FN_FREE4K:
            begin
                push_ent.op  = pg_ok ? OP_FREE4K : OP_BAD;
                push_ent.idx = CIDX_W'(off[12 +: PIDX_W]);
            end
            FN_ALLOC1K: push_ent.op = OP_ALLOC1K;
            FN_FREE1K:
            begin
                push_ent.op  = ck_ok ? OP_FREE1K : OP_BAD;
                push_ent.idx = off[10 +: CIDX_W];
            end
            default:    push_ent.op = OP_QUERY;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        base_next  = base_reg;
        pages_next = pages_reg;
        if (push)
        begin
            valid_next = 1'b0;
            if (push_ent.op == OP_INIT)
            begin
                base_next  = init_s[31:0];
                pages_next = init_n;
            end
        end
        if (accept)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            base_reg  <= '0;
            pages_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            base_reg  <= base_next;
            pages_reg <= pages_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
    end

endmodule

/* hw/rtl/pfla_queue.sv */
// ----------------------------------------------------------------------------
// pfla_queue
// Short first-in first-out queue of classified requests between the front
// and the back.
// ----------------------------------------------------------------------------
module pfla_queue
    import pfla_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t push_ent,
    input  logic  pop,
    output qent_t head_ent,
    output logic  empty,
    output logic  full
);

    qent_t              ent_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_ent = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push_ent;
        end
    end

endmodule

/* hw/rtl/pfla_back.sv */
// ----------------------------------------------------------------------------
// pfla_back
// Holds both free lists in link memories and carries out init, allocate,
// free and query, forming one result per request.
// ----------------------------------------------------------------------------
module pfla_back
    import pfla_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_empty,
    input  qent_t q_ent,
    output logic  q_pop,
    output logic  done,
    output rsp_t  rsp
);

    logic [PHEAD_W-1:0] page_links  [NUM_PAGES];
    logic [CHEAD_W-1:0] chunk_links [NUM_CHUNKS];

    bk_state_t          state_reg, state_next;
    logic [PHEAD_W-1:0] page_head_reg, page_head_next;
    logic [CHEAD_W-1:0] chunk_head_reg, chunk_head_next;
    logic [PHEAD_W-1:0] page_count_reg, page_count_next;
    logic [CHEAD_W-1:0] chunk_count_reg, chunk_count_next;
    logic [31:0]        base_reg, base_next;
    logic [33:0]        walk_addr_reg, walk_addr_next;
    logic [PHEAD_W-1:0] walk_cnt_reg, walk_cnt_next;
    logic [PHEAD_W-1:0] walk_n_reg, walk_n_next;
    logic [PIDX_W-1:0]  split_pg_reg, split_pg_next;
    logic [1:0]         split_j_reg, split_j_next;
    logic               done_reg;
    rsp_t               rsp_reg, rsp_next;
    logic [PHEAD_W-1:0] pg_rdata_reg;
    logic [CHEAD_W-1:0] ck_rdata_reg;

    logic               pg_we;
    logic [PIDX_W-1:0]  pg_waddr;
    logic [PHEAD_W-1:0] pg_wdata;
    logic               ck_we;
    logic [CIDX_W-1:0]  ck_waddr;
    logic [CHEAD_W-1:0] ck_wdata;
    logic               fin;
    logic [31:0]        res_addr;
    logic [1:0]         res_status;

    logic               page_empty;
    logic               chunk_empty;
    logic               walk_last;
    logic               hit0;
    logic               hit1;
    logic               walk_hole;
    logic [CIDX_W-1:0]  split_chunk;
    logic [FBS_W-1:0]   fb_sum;

    function automatic logic [PHEAD_W-1:0] page_inc(input logic [PHEAD_W-1:0] c);
        return (c < PAGE_EMPTY) ? c + 1'b1 : c;
    endfunction

    function automatic logic [PHEAD_W-1:0] page_dec(input logic [PHEAD_W-1:0] c);
        return (c != '0) ? c - 1'b1 : c;
    endfunction

    function automatic logic [CHEAD_W-1:0] chunk_inc(input logic [CHEAD_W-1:0] c);
        return (c < CHUNK_EMPTY) ? c + 1'b1 : c;
    endfunction

    function automatic logic [CHEAD_W-1:0] chunk_dec(input logic [CHEAD_W-1:0] c);
        return (c != '0) ? c - 1'b1 : c;
    endfunction

    function automatic logic hole_hit(input logic [31:0] hb, input logic [31:0] he,
                                      input logic [33:0] a);
        logic [32:0] b;
        logic [32:0] e;
        b = {1'b0, hb[31:12], 12'h000};
        e = ({1'b0, he} + 33'h0_0000_0FFF) & ~33'h0_0000_0FFF;
        return (b != '0) && (a >= {1'b0, b}) && (a <= {1'b0, e});
    endfunction

    assign page_empty  = page_head_reg >= PAGE_EMPTY;
    assign chunk_empty = chunk_head_reg >= CHUNK_EMPTY;
    assign walk_last   = (walk_cnt_reg + 1'b1) == walk_n_reg;
    assign hit0        = hole_hit(cfg.hole0_base, cfg.hole0_end, walk_addr_reg);
    assign hit1        = hole_hit(cfg.hole1_base, cfg.hole1_end, walk_addr_reg);
    assign walk_hole   = cfg.skip_holes && (hit0 || hit1);
    assign split_chunk = {split_pg_reg, split_j_reg};
    assign q_pop       = (state_reg == BK_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_ent.op)
                        OP_INIT:
                        begin
                            if (q_ent.npages != '0)
                            begin
                                state_next = BK_INIT;
                            end
                        end
                        OP_ALLOC4K:
                        begin
                            if (!page_empty)
                            begin
                                state_next = BK_PG_WAIT;
                            end
                        end
                        OP_ALLOC1K:
                        begin
                            if (!chunk_empty)
                            begin
                                state_next = BK_CK_WAIT;
                            end
                            else if (!page_empty)
                            begin
                                state_next = BK_SPLIT_WAIT;
                            end
                        end
                        default: state_next = BK_IDLE;
                    endcase
                end
            end
            BK_INIT:
            begin
                if (walk_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_PG_WAIT:    state_next = BK_IDLE;
            BK_CK_WAIT:    state_next = BK_IDLE;
            BK_SPLIT_WAIT: state_next = BK_SPLIT;
            BK_SPLIT:
            begin
                if (split_j_reg == 2'd3)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:       state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        page_head_next   = page_head_reg;
        chunk_head_next  = chunk_head_reg;
        page_count_next  = page_count_reg;
        chunk_count_next = chunk_count_reg;
        base_next        = base_reg;
        walk_addr_next   = walk_addr_reg;
        walk_cnt_next    = walk_cnt_reg;
        walk_n_next      = walk_n_reg;
        split_pg_next    = split_pg_reg;
        split_j_next     = split_j_reg;
        pg_we            = 1'b0;
        pg_waddr         = q_ent.idx[PIDX_W-1:0];
        pg_wdata         = page_head_reg;
        ck_we            = 1'b0;
        ck_waddr         = q_ent.idx;
        ck_wdata         = chunk_head_reg;
        fin              = 1'b0;
        res_addr         = '0;
        res_status       = ST_OK;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_ent.op)
                        OP_INIT:
                        begin
                            page_head_next   = PAGE_EMPTY;
                            chunk_head_next  = CHUNK_EMPTY;
                            page_count_next  = '0;
                            chunk_count_next = '0;
                            base_next        = q_ent.base[31:0];
                            walk_addr_next   = {1'b0, q_ent.base};
                            walk_cnt_next    = '0;
                            walk_n_next      = q_ent.npages;
                            fin              = (q_ent.npages == '0);
                        end
                        OP_ALLOC4K:
                        begin
                            if (page_empty)
                            begin
                                fin        = 1'b1;
                                res_status = ST_EMPTY;
                            end
                        end
                        OP_FREE4K:
                        begin
                            pg_we           = 1'b1;
                            page_head_next  = PHEAD_W'(q_ent.idx[PIDX_W-1:0]);
                            page_count_next = page_inc(page_count_reg);
                            fin             = 1'b1;
                        end
                        OP_ALLOC1K:
                        begin
                            if (chunk_empty && page_empty)
                            begin
                                fin        = 1'b1;
                                res_status = ST_EMPTY;
                            end
                        end
                        OP_FREE1K:
                        begin
                            ck_we            = 1'b1;
                            chunk_head_next  = CHEAD_W'(q_ent.idx);
                            chunk_count_next = chunk_inc(chunk_count_reg);
                            fin              = 1'b1;
                        end
                        OP_BAD:
                        begin
                            fin        = 1'b1;
                            res_status = ST_BAD;
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            BK_INIT:
            begin
                if (!walk_hole)
                begin
                    pg_we           = 1'b1;
                    pg_waddr        = walk_cnt_reg[PIDX_W-1:0];
                    page_head_next  = walk_cnt_reg;
                    page_count_next = page_inc(page_count_reg);
                end
                walk_cnt_next  = walk_cnt_reg + 1'b1;
                walk_addr_next = walk_addr_reg + 34'h0_0000_1000;
                fin            = walk_last;
            end
            BK_PG_WAIT:
            begin
                page_head_next  = pg_rdata_reg;
                page_count_next = page_dec(page_count_reg);
                res_addr        = base_reg + (32'(page_head_reg[PIDX_W-1:0]) << 12);
                fin             = 1'b1;
            end
            BK_CK_WAIT:
            begin
                chunk_head_next  = ck_rdata_reg;
                chunk_count_next = chunk_dec(chunk_count_reg);
                res_addr         = base_reg + (32'(chunk_head_reg[CIDX_W-1:0]) << 10);
                fin              = 1'b1;
            end
            BK_SPLIT_WAIT:
            begin
                split_pg_next   = page_head_reg[PIDX_W-1:0];
                split_j_next    = 2'd0;
                page_head_next  = pg_rdata_reg;
                page_count_next = page_dec(page_count_reg);
            end
            BK_SPLIT:
            begin
                ck_we        = 1'b1;
                ck_waddr     = split_chunk;
                split_j_next = split_j_reg + 1'b1;
                if (split_j_reg == 2'd3)
                begin
                    chunk_head_next  = CHEAD_W'({split_pg_reg, 2'd2});
                    chunk_count_next = chunk_dec(chunk_inc(chunk_count_reg));
                    res_addr         = base_reg + (32'(split_chunk) << 10);
                    fin              = 1'b1;
                end
                else
                begin
                    chunk_head_next  = CHEAD_W'(split_chunk);
                    chunk_count_next = chunk_inc(chunk_count_reg);
                end
            end
            default: fin = 1'b0;
        endcase
    end

    assign fb_sum = (FBS_W'(chunk_count_next) << 10) + (FBS_W'(page_count_next) << 12);

    always_comb
    begin
        rsp_next.alloc_addr = res_addr;
        rsp_next.status     = res_status;
        rsp_next.free_bytes = (fb_sum > FBS_W'(FB_MAX)) ? FB_MAX : fb_sum[22:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            page_head_reg   <= PAGE_EMPTY;
            chunk_head_reg  <= CHUNK_EMPTY;
            page_count_reg  <= '0;
            chunk_count_reg <= '0;
            base_reg        <= '0;
            walk_cnt_reg    <= '0;
            walk_n_reg      <= '0;
            split_j_reg     <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            page_head_reg   <= page_head_next;
            chunk_head_reg  <= chunk_head_next;
            page_count_reg  <= page_count_next;
            chunk_count_reg <= chunk_count_next;
            base_reg        <= base_next;
            walk_cnt_reg    <= walk_cnt_next;
            walk_n_reg      <= walk_n_next;
            split_j_reg     <= split_j_next;
            done_reg        <= fin;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_addr_reg <= walk_addr_next;
        split_pg_reg  <= split_pg_next;
        if (fin)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pg_we)
        begin
            page_links[pg_waddr] <= pg_wdata;
        end
        pg_rdata_reg <= page_links[page_head_reg[PIDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ck_we)
        begin
            chunk_links[ck_waddr] <= ck_wdata;
        end
        ck_rdata_reg <= chunk_links[chunk_head_reg[CIDX_W-1:0]];
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* hw/rtl/pfla_checker.sv */
// ----------------------------------------------------------------------------
// pfla_checker
// Port-level checks on the allocator's results and request handshake.
// ----------------------------------------------------------------------------
module pfla_checker
    import pfla_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == ST_OK || rsp.status == ST_EMPTY || rsp.status == ST_BAD))
        else $error("result status outside the defined codes");

    a_fail_no_addr : assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> (rsp.alloc_addr == 32'd0))
        else $error("failed request returned an address");

    a_fb_granule : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.free_bytes[9:0] == 10'd0 || rsp.free_bytes == FB_MAX))
        else $error("free byte count is not a whole number of chunks");

    a_busy_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !busy)
        else $error("busy raised with no request taken");

endmodule

bind page_free_list_allocator pfla_checker u_pfla_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
